[hw/rtl/bdclp_pkg.sv]
package bdclp_pkg;

	localparam int BUTTONS     = 4;
	localparam int COUNT_WIDTH = 16;
	localparam int DEB_W       = 8;
	localparam int LONG_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	// per-button findings handed to the merge stage
	typedef struct packed {
		logic pressed;
		logic click;
		logic longp;
	} lane_evt_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		sat_inc = (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

[hw/rtl/bdclp_lane.sv]
module bdclp_lane import bdclp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              raw,
	input  logic [DEB_W-1:0]  debounce_ticks,
	input  logic [LONG_W-1:0] long_press_ticks,
	output lane_evt_t         evt
);

	logic last_raw_q, deb_q, long_done_q, pending_q;
	cnt_t stable_q, hold_q;

	logic raw_chg, deb_flip, acc_press, deb_n, ld_mid, pend_mid, long_hit;
	logic ld_n, pend_n;
	cnt_t stable_n, hold_n;

	always_comb begin
		raw_chg   = raw != last_raw_q;
		stable_n  = raw_chg ? '0 : sat_inc(stable_q);
		deb_flip  = (32'(stable_n) > 32'(debounce_ticks)) && (raw != deb_q);
		deb_n     = deb_flip ? raw : deb_q;
		acc_press = deb_flip && !raw;
		if (acc_press) begin
			hold_n = '0;
		end else if (!deb_n) begin
			hold_n = sat_inc(hold_q);
		end else begin
			hold_n = hold_q;
		end
		ld_mid   = acc_press ? 1'b0 : long_done_q;
		pend_mid = acc_press ? 1'b1 : pending_q;
		long_hit = 1'b0;
		evt      = '0;
		ld_n     = ld_mid;
		pend_n   = pend_mid;
		if (!deb_n) begin
			evt.pressed = 1'b1;
			long_hit    = !ld_mid && (32'(hold_n) >= 32'(long_press_ticks));
			evt.longp   = long_hit;
			ld_n        = ld_mid | long_hit;
		end else if (pend_mid) begin
			pend_n    = 1'b0;
			evt.click = !ld_mid;
			ld_n      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b1;
			deb_q       <= 1'b1;
			stable_q    <= '0;
			hold_q      <= '0;
			long_done_q <= 1'b0;
			pending_q   <= 1'b0;
		end else if (step) begin
			last_raw_q  <= raw;
			deb_q       <= deb_n;
			stable_q    <= stable_n;
			hold_q      <= hold_n;
			long_done_q <= ld_n;
			pending_q   <= pend_n;
		end
	end

endmodule

[hw/rtl/bdclp_merge.sv]
module bdclp_merge import bdclp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lane_evt_t [BUTTONS-1:0]   evt,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [BUTTONS-1:0]        pressed_mask,
	output logic [BUTTONS-1:0]        click_mask,
	output logic [BUTTONS-1:0]        long_press_mask
);

	logic [BUTTONS-1:0] p_n, c_n, l_n;
	logic [BUTTONS-1:0] p_q, c_q, l_q, sp_q, sc_q, sl_q;
	logic               out_v_q, skid_v_q, in_acc;

	always_comb begin
		for (int i = 0; i < BUTTONS; i++) begin
			p_n[i] = evt[i].pressed;
			c_n[i] = evt[i].click;
			l_n[i] = evt[i].longp;
		end
	end

	assign in_ready = !skid_v_q;
	assign in_acc   = in_valid && in_ready;

	// main output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
			if (in_acc) begin
				if (!out_v_q || out_ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && out_ready && skid_v_q) begin
			p_q <= sp_q;
			c_q <= sc_q;
			l_q <= sl_q;
		end
		if (in_acc) begin
			if (!out_v_q || out_ready) begin
				p_q <= p_n;
				c_q <= c_n;
				l_q <= l_n;
			end else begin
				sp_q <= p_n;
				sc_q <= c_n;
				sl_q <= l_n;
			end
		end
	end

	assign out_valid       = out_v_q;
	assign pressed_mask    = p_q;
	assign click_mask      = c_q;
	assign long_press_mask = l_q;

endmodule

[hw/rtl/button_debounce_click_long_press_top.sv]
// Four-button debouncer with click and long-press events. Each accepted item is one
// tick carrying the raw active-low button levels; it yields one result item with the
// debounced pressed mask and one-tick click and long-press masks. One item per clock
// while the skid buffer is empty: every button has its own lane of counters updated
// in the accepting cycle, and a registered merge stage with a one-entry skid buffer
// delivers the result. Registers (debounce_ticks at index 0, long_press_ticks at
// index 1) should be written only while no item is in flight.
module button_debounce_click_long_press_top import bdclp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BUTTONS-1:0]   raw_levels,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BUTTONS-1:0]   pressed_mask,
	output logic [BUTTONS-1:0]   click_mask,
	output logic [BUTTONS-1:0]   long_press_mask
);

	logic [DEB_W-1:0]        deb_ticks_q;
	logic [LONG_W-1:0]       long_ticks_q;
	lane_evt_t [BUTTONS-1:0] evt;
	logic                    step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ticks_q  <= DEB_W'(50);
			long_ticks_q <= LONG_W'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   deb_ticks_q  <= cfg_data[DEB_W-1:0];
				REG_LONG_PRESS: long_ticks_q <= cfg_data[LONG_W-1:0];
				default: ;
			endcase
		end
	end

	assign step = in_valid && in_ready;

	for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
		bdclp_lane u_lane (
			.clk              (clk),
			.arst_n           (arst_n),
			.step             (step),
			.raw              (raw_levels[g]),
			.debounce_ticks   (deb_ticks_q),
			.long_press_ticks (long_ticks_q),
			.evt              (evt[g])
		);
	end

	bdclp_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.evt             (evt),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pressed_mask    (pressed_mask),
		.click_mask      (click_mask),
		.long_press_mask (long_press_mask)
	);

endmodule
